>>> src/sst_pkg.sv
// Package for the semiprime test block: table sizing, derived widths and
// the controller state encoding. No dependencies.
`default_nettype none

package sst_pkg;

    localparam int TABLE_SIZE = 131072;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    // trial divisor: one past floor(sqrt(TABLE_SIZE-1)) must fit
    localparam int D_W        = ADDR_W / 2 + 1;
    localparam int SQ_W       = 2 * D_W;
    localparam int CNT_W      = $clog2(ADDR_W);
    localparam int S_TDATA_W  = ((ADDR_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;

    localparam logic [SQ_W-1:0]   TABLE_LIM = SQ_W'(TABLE_SIZE);
    localparam logic [ADDR_W:0]   TABLE_END = (ADDR_W + 1)'(TABLE_SIZE);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(ADDR_W - 1);

    typedef enum logic [3:0] {
        ST_FILL,     // write initial prime flags, one entry a cycle
        ST_SV_RD,    // read flag of sieve base i
        ST_SV_CHK,   // base flag arrives
        ST_MARK,     // clear multiples of i
        ST_IDLE,     // ready for a query
        ST_Q_TEST,   // d*d <= n check
        ST_Q_DIV,    // restoring division, one bit a cycle
        ST_Q_CHK,    // remainder check, read flag of quotient
        ST_Q_RDQ,    // quotient flag arrives, read flag of d
        ST_Q_RDD,    // divisor flag arrives, decide
        ST_Q_OUT     // hand result to output register
    } sst_state_t;

endpackage

`default_nettype wire

>>> src/semiprime_test_with_sieve.sv
// Semiprime test with a sieve-built prime-flag memory.
// Depends on sst_pkg (sizing constants, state type).
`default_nettype none

// After reset the block builds a one-bit prime flag for every value below
// TABLE_SIZE (131072) in an internal synchronous RAM: a fill pass, then a
// sieve of Eratosthenes that clears multiples of each prime base below
// sqrt(TABLE_SIZE), one RAM write a cycle. s_tready stays low until this
// is done. Each query item (s_tdata[16:0]) is then tested one item at a
// time: each trial divisor d = 1, 2, ... while d*d <= n takes a bound test,
// a restoring division and a remainder check, plus flag reads on the
// single RAM read port when d divides n. The answer (m_tdata[0]) is 1 when
// n = p*q with p, q distinct primes. The result sits in an output register,
// so the next query is accepted while it waits for m_tready.
module semiprime_test_with_sieve (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire  [sst_pkg::S_TDATA_W-1:0] s_tdata,  // [16:0] query_value
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [sst_pkg::M_TDATA_W-1:0] m_tdata   // [0] is_semiprime_flag
);
    import sst_pkg::*;

    sst_state_t          state_reg, state_next;
    logic                sieve_done_reg, sieve_done_next;
    logic [ADDR_W:0]     m_reg, m_next;        // fill address / multiple
    logic [D_W-1:0]      i_reg, i_next;        // sieve base
    logic [SQ_W-1:0]     isq_reg, isq_next;    // i*i, kept incrementally
    logic [ADDR_W-1:0]   num_reg, num_next;
    logic [D_W-1:0]      d_reg, d_next;        // trial divisor
    logic [SQ_W-1:0]     dsq_reg, dsq_next;    // d*d, kept incrementally
    logic [D_W-1:0]      rem_reg, rem_next;
    logic [ADDR_W-1:0]   quo_reg, quo_next;    // dividend in, quotient out
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                flag_q_reg, flag_q_next;
    logic                hit_reg, hit_next;    // answer of the running query
    logic                m_tvalid_reg, m_tvalid_next;
    logic                res_reg, res_next;

    // prime flag RAM, one write port, one registered read port
    logic                prime_mem [TABLE_SIZE];
    logic                rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic                wr_en;
    logic                wr_data;

    logic [D_W:0]        trial;
    logic                trial_ge;
    logic [ADDR_W:0]     m_step;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - 1){1'b0}}, res_reg};

    assign trial    = {rem_reg, quo_reg[ADDR_W-1]};
    assign trial_ge = (trial >= {1'b0, d_reg});
    assign m_step   = m_reg + {{(ADDR_W + 1 - D_W){1'b0}}, i_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            prime_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= prime_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FILL;
            sieve_done_reg <= 1'b0;
            m_reg          <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sieve_done_reg <= sieve_done_next;
            m_reg          <= m_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        isq_reg    <= isq_next;
        num_reg    <= num_next;
        d_reg      <= d_next;
        dsq_reg    <= dsq_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        flag_q_reg <= flag_q_next;
        hit_reg    <= hit_next;
        res_reg    <= res_next;
    end

    always_comb begin
        state_next      = state_reg;
        sieve_done_next = sieve_done_reg;
        m_next          = m_reg;
        i_next          = i_reg;
        isq_next        = isq_reg;
        num_next        = num_reg;
        d_next          = d_reg;
        dsq_next        = dsq_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        flag_q_next     = flag_q_reg;
        hit_next        = hit_reg;
        res_next        = res_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        rd_addr         = quo_reg;
        wr_addr         = m_reg[ADDR_W-1:0];
        wr_en           = 1'b0;
        wr_data         = 1'b0;

        unique case (state_reg)
            ST_FILL: begin
                // 0 and 1 are not prime, everything else starts as prime
                wr_en   = 1'b1;
                wr_data = (m_reg[ADDR_W-1:0] > ADDR_W'(1));
                m_next  = m_reg + 1'b1;
                if (m_reg[ADDR_W-1:0] == LAST_ADDR) begin
                    i_next     = D_W'(2);
                    isq_next   = SQ_W'(4);
                    state_next = ST_SV_RD;
                end
            end
            ST_SV_RD: begin
                rd_addr = ADDR_W'(i_reg);
                if (isq_reg < TABLE_LIM) begin
                    state_next = ST_SV_CHK;
                end else begin
                    sieve_done_next = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SV_CHK: begin
                if (rd_data_reg) begin
                    m_next     = {1'b0, ADDR_W'(i_reg)} << 1;
                    state_next = ST_MARK;
                end else begin
                    i_next     = i_reg + 1'b1;
                    isq_next   = isq_reg + {(SQ_W - 1)'(i_reg), 1'b1};
                    state_next = ST_SV_RD;
                end
            end
            ST_MARK: begin
                wr_en   = 1'b1;
                wr_data = 1'b0;
                m_next  = m_step;
                if (m_step >= TABLE_END) begin
                    i_next     = i_reg + 1'b1;
                    isq_next   = isq_reg + {(SQ_W - 1)'(i_reg), 1'b1};
                    state_next = ST_SV_RD;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    num_next   = s_tdata[ADDR_W-1:0];
                    d_next     = D_W'(1);
                    dsq_next   = SQ_W'(1);
                    state_next = ST_Q_TEST;
                end
            end
            ST_Q_TEST: begin
                if (dsq_reg > SQ_W'(num_reg)) begin
                    hit_next   = 1'b0;
                    state_next = ST_Q_OUT;
                end else begin
                    rem_next   = '0;
                    quo_next   = num_reg;
                    cnt_next   = '0;
                    state_next = ST_Q_DIV;
                end
            end
            ST_Q_DIV: begin
                // restoring division, quotient bits shift in from the bottom
                rem_next = trial_ge ? D_W'(trial - {1'b0, d_reg}) : trial[D_W-1:0];
                quo_next = {quo_reg[ADDR_W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_Q_CHK;
                end
            end
            ST_Q_CHK: begin
                rd_addr = quo_reg;
                if (rem_reg != '0) begin
                    d_next     = d_reg + 1'b1;
                    dsq_next   = dsq_reg + {(SQ_W - 1)'(d_reg), 1'b1};
                    state_next = ST_Q_TEST;
                end else begin
                    state_next = ST_Q_RDQ;
                end
            end
            ST_Q_RDQ: begin
                rd_addr     = ADDR_W'(d_reg);
                flag_q_next = rd_data_reg;
                state_next  = ST_Q_RDD;
            end
            ST_Q_RDD: begin
                if (flag_q_reg && rd_data_reg && (quo_reg != ADDR_W'(d_reg))) begin
                    hit_next   = 1'b1;
                    state_next = ST_Q_OUT;
                end else begin
                    d_next     = d_reg + 1'b1;
                    dsq_next   = dsq_reg + {(SQ_W - 1)'(d_reg), 1'b1};
                    state_next = ST_Q_TEST;
                end
            end
            ST_Q_OUT: begin
                // wait for the output register to free up, then load it
                if (!m_tvalid_reg || m_tready) begin
                    res_next      = hit_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    // no query is taken before the table is complete
    a_ready_after_sieve: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> sieve_done_reg)
        else $error("query accepted before sieve finished");

    // the flag RAM is only written while it is being built
    a_write_in_build: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (!sieve_done_reg && (state_reg == ST_FILL || state_reg == ST_MARK)))
        else $error("flag RAM written after sieve");

    // an accepted query starts its divisor loop
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_Q_TEST && d_reg == D_W'(1)))
        else $error("query did not start at divisor one");

    // the divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_Q_DIV) |-> (d_reg != '0))
        else $error("division by zero");

    // a result is loaded only into a free or draining output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_Q_OUT && m_tvalid_reg && !m_tready) |=>
            (state_reg == ST_Q_OUT && m_tvalid_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> bench/semiprime_answer_checker.sv
// Answer checker for semiprime_test_with_sieve: watches the query and answer
// channels, predicts every answer from a prime table of its own and compares.
// Depends on sst_pkg (table size, channel widths).
`default_nettype none

module semiprime_answer_checker (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    input  wire                           s_tready,
    input  wire  [sst_pkg::S_TDATA_W-1:0] s_tdata,  // [16:0] query_value
    input  wire                           m_tvalid,
    input  wire                           m_tready,
    input  wire  [sst_pkg::M_TDATA_W-1:0] m_tdata,  // [0] is_semiprime_flag
    output int                            n_pending,
    output int                            n_checked,
    output int                            n_semiprime,
    output int                            n_errors
);

    localparam int TBL    = sst_pkg::TABLE_SIZE;
    localparam int ADDR_W = sst_pkg::ADDR_W;

    typedef struct packed {
        logic [ADDR_W-1:0] query;
        logic              flag;
    } answer_t;

    bit      prime_tbl [TBL];
    answer_t answer_q [$];
    int      err_cnt  = 0;
    int      chk_cnt  = 0;
    int      semi_cnt = 0;

    // prime table built once at time zero
    initial begin
        for (int v = 0; v < TBL; v++) prime_tbl[v] = (v >= 2);
        for (int b = 2; b * b < TBL; b++) begin
            if (prime_tbl[b]) begin
                for (int m = b + b; m < TBL; m += b) prime_tbl[m] = 1'b0;
            end
        end
    end

    // 1 when some divisor pair d, n/d with d*d <= n is two distinct primes
    function automatic logic semiprime_answer(input logic [ADDR_W-1:0] n);
        int unsigned k;
        for (int unsigned d = 1; d * d <= n; d++) begin
            if (n % d == 0) begin
                k = n / d;
                if (prime_tbl[k] && prime_tbl[d] && k != d) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    always @(posedge aclk) begin : watch
        answer_t                       exp_a;
        logic [sst_pkg::M_TDATA_W-1:0] exp_data;
        if (!aresetn) begin
            answer_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                exp_a.query = s_tdata[ADDR_W-1:0];
                exp_a.flag  = semiprime_answer(s_tdata[ADDR_W-1:0]);
                answer_q    = {answer_q, exp_a};
            end
            if (m_tvalid && m_tready) begin
                if (answer_q.size() == 0) begin
                    if (err_cnt < 10)
                        $display("ERROR: answer %0h with no query outstanding", m_tdata);
                    err_cnt++;
                end else begin
                    exp_a    = answer_q.pop_front();
                    exp_data = sst_pkg::M_TDATA_W'(exp_a.flag);  // pad bits zero
                    chk_cnt++;
                    if (m_tdata[0]) semi_cnt++;
                    if (m_tdata !== exp_data) begin
                        if (err_cnt < 10)
                            $display("ERROR: query %0d: expected answer %0h, got %0h",
                                     exp_a.query, exp_data, m_tdata);
                        err_cnt++;
                    end
                end
            end
        end
        n_pending   <= answer_q.size();
        n_checked   <= chk_cnt;
        n_semiprime <= semi_cnt;
        n_errors    <= err_cnt;
    end

endmodule

`default_nettype wire

>>> bench/semiprime_test_with_sieve_tb.sv
// Top of the semiprime_test_with_sieve bench: clock, reset, query stimulus,
// answer-side back-pressure and the verdict.
// Depends on sst_pkg, semiprime_test_with_sieve and semiprime_answer_checker.
`default_nettype none

module semiprime_test_with_sieve_tb;

    localparam int     CLK_PERIOD   = 12;
    localparam int     RESET_CYCLES = 11;
    localparam int     N_RANDOM     = 80;
    localparam int     MAX_IDLE     = 14;
    localparam int     N_DIRECTED   = 20;
    localparam int     N_PRIMES     = 40;
    // a stray answer could take as long as the slowest query
    localparam int     TAIL_CYCLES  = 8000;
    // slowest pass: the sieve, then 100 queries at their worst case
    // each; taken about five times over
    localparam longint CYCLE_LIMIT  = 6_000_000;
    localparam int     TBL          = sst_pkg::TABLE_SIZE;
    localparam int     ADDR_W       = sst_pkg::ADDR_W;

    logic                          aclk;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [sst_pkg::S_TDATA_W-1:0] s_tdata  = '0;  // [16:0] query_value
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [sst_pkg::M_TDATA_W-1:0] m_tdata;        // [0] is_semiprime_flag

    int     n_pending;
    int     n_checked;
    int     n_semiprime;
    int     n_errors;
    int     n_sent = 0;
    longint cycles = 0;

    // factors for building well-formed products; last ones near each power of 2
    int unsigned prime_pool [N_PRIMES] = '{
        2, 3, 5, 7, 11, 13, 17, 19, 23, 29,
        31, 37, 41, 43, 47, 53, 59, 61, 67, 71,
        73, 79, 83, 89, 97, 101, 127, 131, 251, 257,
        353, 359, 509, 1021, 2039, 4093, 8191, 16381, 32749, 65521
    };

    // directed queries
    int unsigned directed_q [N_DIRECTED] = '{
        0,       // zero: no divisor qualifies
        1,       // one
        2,       // a prime on its own
        3,
        4,       // square of a prime
        6,       // smallest product of two distinct primes
        21,
        30,      // three prime factors
        35,
        49,      // square of a prime
        65535,   // 3*5*17*257
        65536,   // single high bit, power of two
        43690,   // 0x0AAAA
        87381,   // 0x15555
        126727,  // 353*359: found only at a deep divisor
        128881,  // 359*359: largest square of a prime in range
        130321,  // 19^4
        131042,  // 2*65521: cofactor near the top of the table
        131070,  // 0x1FFFE
        131071   // all ones, itself prime
    };

    semiprime_test_with_sieve u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    semiprime_answer_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .n_pending   (n_pending),
        .n_checked   (n_checked),
        .n_semiprime (n_semiprime),
        .n_errors    (n_errors)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d answers still outstanding",
                     cycles, n_pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // One query item. A zero gap keeps tvalid high straight from the
    // previous item, so tvalid is never dropped and raised in one step.
    task automatic send_query(input int unsigned value, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= sst_pkg::S_TDATA_W'(value[ADDR_W-1:0]);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    // Answer side: stall per item, with runs of eight items without stalls
    initial begin : answer_sink
        int stall;
        bit calm;
        int n_taken;
        n_taken = 0;
        calm    = 1'b0;
        forever begin
            if (n_taken % 8 == 0) calm = ($urandom_range(0, 2) == 0);
            stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            n_taken++;
        end
    end

    initial begin : query_source
        int unsigned value;
        int unsigned p;
        int unsigned q;
        int          kind;
        bit          calm;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. The first query is offered right after reset, so it
        // sits waiting while the sieve is still filling the table; the first
        // few go back to back.
        for (int i = 0; i < N_DIRECTED; i++) send_query(directed_q[i], i < 6);
        s_tvalid <= 1'b0;

        // hold off until every directed answer is back
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);

        // Random part: products of primes as the most common kind, plus squares of
        // primes, small values and values over the whole field.
        calm = 1'b0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 10 == 0) calm = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                // two primes, usually distinct; fall back to a small second
                // factor, then to the prime alone, if the product overflows
                p = prime_pool[$urandom_range(0, N_PRIMES - 1)];
                q = prime_pool[$urandom_range(0, N_PRIMES - 1)];
                if (p * q >= TBL) q = prime_pool[$urandom_range(0, 8)];
                value = (p * q < TBL) ? p * q : p;
                // sometimes a third factor
                if (kind == 0 && value * 3 < TBL) value = value * 3;
            end else if (kind == 4) begin
                // square of a prime
                p     = prime_pool[$urandom_range(0, 31)];
                value = p * p;
            end else if (kind <= 6) begin
                value = $urandom_range(0, 4095);
            end else begin
                value = $urandom_range(0, TBL - 1);
            end
            send_query(value, calm);
        end
        s_tvalid <= 1'b0;

        // drain, then watch a while longer for stray answers
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d queries (%0d directed, %0d random) after the sieve pass,",
                 n_sent, N_DIRECTED, n_sent - N_DIRECTED);
        $display("checked %0d answers, %0d of them semiprime, in %0d cycles",
                 n_checked, n_semiprime, cycles);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
